@@ sv/coap_ser_pkg.sv @@
// Shared types, constants and encoding functions for the CoAP message serializer.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package coap_ser_pkg;

	typedef enum logic [2:0] {
		ACT_HEADER = 3'd0,
		ACT_OPAQUE = 3'd1,
		ACT_UINT   = 3'd2,
		ACT_MARKER = 3'd3,
		ACT_DATA   = 3'd4
	} action_t;

	localparam logic [15:0] EXT1_BASE  = 16'd13;
	localparam logic [15:0] EXT2_BASE  = 16'd269;
	localparam logic [3:0]  NIB_EXT1   = 4'hD;
	localparam logic [3:0]  NIB_EXT2   = 4'hE;
	localparam logic [7:0]  VER1_BITS  = 8'h40;
	localparam logic [7:0]  MARKER     = 8'hFF;
	localparam logic [15:0] MAX_AGE_ID = 16'd14;
	localparam logic [3:0]  TKL_MAX    = 4'd8;
	localparam int unsigned QDEPTH     = 4;
	localparam int unsigned QPTR_W     = $clog2(QDEPTH);

	// Up to five bytes of option tag, left aligned, with a byte count.
	typedef struct packed {
		logic [39:0] bytes;
		logic [2:0]  n;
	} tag_t;

	// One queued job: bytes of segment a, then segment b (both left aligned),
	// then the low c_n bytes of c_val sent big-endian.
	typedef struct packed {
		logic [15:0] a_bytes;
		logic [1:0]  a_n;
		logic [39:0] b_bytes;
		logic [2:0]  b_n;
		logic [63:0] c_val;
		logic [3:0]  c_n;
		logic        ok;
	} desc_t;

	function automatic logic [3:0] byte_count(input logic [63:0] x);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			if (x[8*i +: 8] != 8'h00) begin
				n = 4'(i + 1);
			end
		end
		return n;
	endfunction

	function automatic logic [3:0] nibble(input logic [15:0] v);
		if (v < EXT1_BASE) begin
			return v[3:0];
		end else if (v < EXT2_BASE) begin
			return NIB_EXT1;
		end else begin
			return NIB_EXT2;
		end
	endfunction

	function automatic logic [1:0] ext_len(input logic [15:0] v);
		if (v < EXT1_BASE) begin
			return 2'd0;
		end else if (v < EXT2_BASE) begin
			return 2'd1;
		end else begin
			return 2'd2;
		end
	endfunction

	// Extension bytes, left aligned in 16 bits.
	function automatic logic [15:0] ext_bytes(input logic [15:0] v);
		logic [15:0] d1;
		logic [15:0] d2;
		d1 = v - EXT1_BASE;
		d2 = v - EXT2_BASE;
		if (v < EXT2_BASE) begin
			return {d1[7:0], 8'h00};
		end else begin
			return d2;
		end
	endfunction

	function automatic tag_t tag_enc(input logic [15:0] delta, input logic [15:0] len);
		tag_t        t;
		logic [1:0]  dn;
		logic [1:0]  ln;
		logic [39:0] lx;
		dn = ext_len(delta);
		ln = ext_len(len);
		t.bytes = {nibble(delta), nibble(len), 32'h0};
		if (dn != 2'd0) begin
			t.bytes[31:16] = ext_bytes(delta);
		end
		lx = {8'h00, ext_bytes(len), 16'h0000} >> {dn, 3'b000};
		if (ln != 2'd0) begin
			t.bytes = t.bytes | lx;
		end
		t.n = 3'd1 + 3'(dn) + 3'(ln);
		return t;
	endfunction

endpackage

@@ sv/coap_ser_front.sv @@
// Front end of the CoAP serializer: accepts items, tracks option order and Max-Age.
// Builds one job descriptor per item of a known action for the queue; uses coap_ser_pkg.
module coap_ser_front import coap_ser_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [1:0]  msg_type,
	input  logic [7:0]  code,
	input  logic [15:0] msg_id,
	input  logic [63:0] token,
	input  logic [3:0]  token_len,
	input  logic [15:0] option_id,
	input  logic [15:0] option_len,
	input  logic [63:0] uint_value,
	input  logic [7:0]  data_byte,
	input  logic        q_full,
	output logic        q_push,
	output desc_t       q_data
);

	logic        auto_max_age_q;
	logic        pending_q;
	logic [15:0] last_option_q;

	logic        pending_d;
	logic [15:0] last_option_d;
	logic        accept;
	logic        known;
	logic [15:0] id_chk;
	logic        ins_ok;
	logic        clr;
	logic [15:0] lo1;
	tag_t        ma_tag;
	tag_t        opt_tag;
	logic [15:0] opt_len;
	logic [3:0]  uint_n;
	logic        opt_ok;
	logic [3:0]  tkl;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		id_chk  = (action == ACT_MARKER) ? 16'd0 : option_id;
		clr     = pending_q && ((id_chk == 16'd0) || (id_chk >= MAX_AGE_ID));
		// The inserted tag is dropped when the previous option is already past Max-Age.
		ins_ok  = pending_q && ((id_chk == 16'd0) || (id_chk > MAX_AGE_ID))
			&& (last_option_q <= MAX_AGE_ID);
		ma_tag  = tag_enc(MAX_AGE_ID - last_option_q, 16'd0);
		lo1     = ins_ok ? MAX_AGE_ID : last_option_q;
		uint_n  = byte_count(uint_value);
		opt_len = (action == ACT_UINT) ? {12'd0, uint_n} : option_len;
		opt_ok  = (option_id >= lo1);
		opt_tag = tag_enc(option_id - lo1, opt_len);
		tkl     = (token_len > TKL_MAX) ? TKL_MAX : token_len;
		if (tkl == 4'd0) begin
			tkl = byte_count(token);
		end

		known         = 1'b1;
		pending_d     = pending_q;
		last_option_d = last_option_q;
		q_data        = '0;
		q_data.ok     = 1'b1;
		unique case (action)
			ACT_HEADER: begin
				last_option_d  = 16'd0;
				pending_d      = auto_max_age_q && (code != 8'h00);
				q_data.b_bytes = {VER1_BITS | {2'b00, msg_type, tkl}, code, msg_id, 8'h00};
				q_data.b_n     = 3'd4;
				q_data.c_val   = token;
				q_data.c_n     = tkl;
			end
			ACT_OPAQUE, ACT_UINT: begin
				if (clr) begin
					pending_d = 1'b0;
				end
				if (ins_ok) begin
					q_data.a_bytes = ma_tag.bytes[39:24];
					q_data.a_n     = ma_tag.n[1:0];
				end
				q_data.ok     = opt_ok;
				last_option_d = opt_ok ? option_id : lo1;
				if (opt_ok) begin
					q_data.b_bytes = opt_tag.bytes;
					q_data.b_n     = opt_tag.n;
					if (action == ACT_UINT) begin
						q_data.c_val = uint_value;
						q_data.c_n   = uint_n;
					end
				end
			end
			ACT_MARKER: begin
				if (clr) begin
					pending_d = 1'b0;
				end
				if (ins_ok) begin
					q_data.a_bytes = ma_tag.bytes[39:24];
					q_data.a_n     = ma_tag.n[1:0];
				end
				last_option_d  = lo1;
				q_data.b_bytes = {MARKER, 32'h0};
				q_data.b_n     = 3'd1;
			end
			ACT_DATA: begin
				q_data.b_bytes = {data_byte, 32'h0};
				q_data.b_n     = 3'd1;
			end
			default: begin
				known = 1'b0;
			end
		endcase
		q_push = accept && known;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_max_age_q <= 1'b1;
			pending_q      <= 1'b1;
			last_option_q  <= '0;
		end else begin
			if (cfg_we) begin
				auto_max_age_q <= cfg_data[0];
			end
			if (accept && known) begin
				pending_q     <= pending_d;
				last_option_q <= last_option_d;
			end
		end
	end

endmodule

@@ sv/coap_ser_fifo.sv @@
// Short job queue between the serializer front and back ends.
// Holds desc_t entries from coap_ser_pkg.
module coap_ser_fifo import coap_ser_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output desc_t head
);

	desc_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full      = (count_q == (QPTR_W+1)'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/coap_ser_back.sv @@
// Back end of the CoAP serializer: walks one job descriptor a byte per cycle unless the output stalls.
// Drives the registered output channel; uses coap_ser_pkg.
module coap_ser_back import coap_ser_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_not_empty,
	input  desc_t       q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        last,
	output logic        ok
);

	logic        cur_v_q;
	logic [15:0] a_q;
	logic [1:0]  a_n_q;
	logic [39:0] b_q;
	logic [2:0]  b_n_q;
	logic [63:0] c_q;
	logic [3:0]  c_n_q;
	logic        ok_q;

	logic        out_v_q;
	logic [7:0]  byte_q;
	logic        bvalid_q;
	logic        last_q;
	logic        okout_q;

	logic        step;
	logic        done;
	logic        load;
	logic [4:0]  rem;
	logic [2:0]  cidx;
	logic [7:0]  nbyte;
	logic        nvalid;

	assign out_valid  = out_v_q;
	assign out_byte   = byte_q;
	assign byte_valid = bvalid_q;
	assign last       = last_q;
	assign ok         = okout_q;

	always_comb begin
		step   = cur_v_q && (!out_v_q || out_ready);
		rem    = 5'(a_n_q) + 5'(b_n_q) + 5'(c_n_q);
		done   = (rem <= 5'd1);
		load   = q_not_empty && (!cur_v_q || (step && done));
		q_pop  = load;
		cidx   = 3'(c_n_q - 4'd1);
		nvalid = 1'b1;
		if (a_n_q != 2'd0) begin
			nbyte = a_q[15:8];
		end else if (b_n_q != 3'd0) begin
			nbyte = b_q[39:32];
		end else if (c_n_q != 4'd0) begin
			nbyte = c_q[{cidx, 3'b000} +: 8];
		end else begin
			// Item with nothing to send still answers with one empty result.
			nbyte  = 8'h00;
			nvalid = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_q   <= q_head.a_bytes;
			a_n_q <= q_head.a_n;
			b_q   <= q_head.b_bytes;
			b_n_q <= q_head.b_n;
			c_q   <= q_head.c_val;
			c_n_q <= q_head.c_n;
			ok_q  <= q_head.ok;
		end else if (step) begin
			if (a_n_q != 2'd0) begin
				a_q   <= {a_q[7:0], 8'h00};
				a_n_q <= a_n_q - 2'd1;
			end else if (b_n_q != 3'd0) begin
				b_q   <= {b_q[31:0], 8'h00};
				b_n_q <= b_n_q - 3'd1;
			end else if (c_n_q != 4'd0) begin
				c_n_q <= c_n_q - 4'd1;
			end
		end
		if (step) begin
			byte_q   <= nbyte;
			bvalid_q <= nvalid;
			last_q   <= done;
			okout_q  <= ok_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				cur_v_q <= 1'b1;
			end else if (step && done) begin
				cur_v_q <= 1'b0;
			end
			if (step) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

@@ sv/coap_message_serializer_core.sv @@
// CoAP message serializer, top level. The first byte of an accepted item passes through
// the job queue, the back end's job registers and its output register. Throughput:
// one result per cycle unless the output stalls, one to thirteen per item, while the
// front takes one item a cycle as long as its four-entry job queue has room; an unused
// action code yields no result. Reset is asynchronous and active low: it empties the queue,
// sets auto_max_age and the Max-Age pending flag to 1 and clears the option tracking.
module coap_message_serializer_core import coap_ser_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [1:0]  msg_type,
	input  logic [7:0]  code,
	input  logic [15:0] msg_id,
	input  logic [63:0] token,
	input  logic [3:0]  token_len,
	input  logic [15:0] option_id,
	input  logic [15:0] option_len,
	input  logic [63:0] uint_value,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        last,
	output logic        ok
);

	// The front end classifies each transaction and settles all message state
	// (option order and the Max-Age pending flag) at the moment of acceptance.
	// What it hands on is a self-contained job: an optional inserted Max-Age tag,
	// a tag or header segment, and a big-endian value segment. Unused action
	// codes are accepted and dropped without a job.
	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_not_empty;
	desc_t q_wdata;
	desc_t q_head;

	coap_ser_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.msg_type   (msg_type),
		.code       (code),
		.msg_id     (msg_id),
		.token      (token),
		.token_len  (token_len),
		.option_id  (option_id),
		.option_len (option_len),
		.uint_value (uint_value),
		.data_byte  (data_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	// The queue lets the front keep taking transactions while the back end
	// is still streaming a long header or uint option.
	coap_ser_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// The back end emits one byte per cycle, unless the output stalls, into a registered output
	// stage and loads the next job in the same cycle as the final byte of the current one.
	coap_ser_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last        (last),
		.ok          (ok)
	);

endmodule

@@ bench/coap_message_serializer_core_test.sv @@
// Self-checking testbench for coap_message_serializer_core: directed table, then random CoAP
// messages and noise, each output byte checked against typed bytes or a stream encoder.
// Depends on coap_ser_pkg for the action codes and on the core RTL only.
module coap_message_serializer_core_test import coap_ser_pkg::*; ();

	// Encoding constants of RFC 7252 as the encoder below uses them.
	localparam int unsigned EXT_ONE_BYTE   = 13;
	localparam int unsigned EXT_TWO_BYTE   = 269;
	localparam logic [3:0]  NIB_ONE_BYTE   = 4'hD;
	localparam logic [3:0]  NIB_TWO_BYTE   = 4'hE;
	localparam logic [7:0]  VER_BITS       = 8'h40;
	localparam logic [7:0]  END_OF_OPTIONS = 8'hFF;
	localparam int unsigned MAX_AGE_OPTION = 14;
	localparam logic [3:0]  TOKEN_MAX      = 4'd8;

	// Action codes the block must swallow without output.
	localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

	// A table row with no bytes typed in is checked against the encoder.
	localparam int PREDICT       = 0;
	localparam int NUM_DIRECTED  = 25;
	localparam int PHASE_ITEMS   = 108;
	localparam int NUM_PHASES    = 4;
	// The settle wait leaves ample slack for an unused action that is still inside the front
	// end when the stream has drained.
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_STALL    = 300;
	localparam int QUIET_LIMIT   = 2000;

	typedef struct packed {
		logic [2:0]  action;
		logic [1:0]  msg_type;
		logic [7:0]  code;
		logic [15:0] msg_id;
		logic [63:0] token;
		logic [3:0]  token_len;
		logic [15:0] option_id;
		logic [15:0] option_len;
		logic [63:0] uint_value;
		logic [7:0]  data_byte;
	} coap_item_t;

	// One serialized byte as the block presents it.
	typedef struct packed {
		logic [7:0] obyte;
		logic       bvalid;
		logic       blast;
		logic       bok;
	} wire_byte_t;

	// Stimulus row: the bytes are left aligned in exp_bytes, the first in bits 63:56.
	typedef struct {
		coap_item_t item;
		int         exp_n;
		logic [63:0] exp_bytes;
		logic       exp_bv;
		logic       exp_ok;
	} item_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  action = '0;
	logic [1:0]  msg_type = '0;
	logic [7:0]  code = '0;
	logic [15:0] msg_id = '0;
	logic [63:0] token = '0;
	logic [3:0]  token_len = '0;
	logic [15:0] option_id = '0;
	logic [15:0] option_len = '0;
	logic [63:0] uint_value = '0;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        last;
	logic        ok;

	// Encoder state, mirroring the option tracking inside the block.
	logic [15:0] prev_option = '0;
	logic        max_age_armed = 1'b1;
	logic        cfg_auto_max_age = 1'b1;

	logic [7:0]  encoded[$];
	wire_byte_t  wire_bytes_q[$];
	int          mismatch_count = 0;
	int          items_sent = 0;
	int          quiet_cycles = 0;
	int          stall_left = 0;
	bit          calm = 1'b0;
	bit          long_stall_req = 1'b0;
	bit          long_stall_seen = 1'b0;

	item_row_t   directed_rows [NUM_DIRECTED];

	coap_message_serializer_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.msg_type   (msg_type),
		.code       (code),
		.msg_id     (msg_id),
		.token      (token),
		.token_len  (token_len),
		.option_id  (option_id),
		.option_len (option_len),
		.uint_value (uint_value),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.ok         (ok)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Stream encoder.
	// ------------------------------------------------------------------

	// Number of significant bytes, zero for a zero value.
	function automatic int unsigned count_bytes(logic [63:0] x);
		int unsigned n;
		n = 0;
		while (x != 64'h0) begin
			n++;
			x = x >> 8;
		end
		return n;
	endfunction

	function automatic logic [3:0] tag_nibble(int unsigned v);
		if (v < EXT_ONE_BYTE) begin
			return 4'(v);
		end else if (v < EXT_TWO_BYTE) begin
			return NIB_ONE_BYTE;
		end
		return NIB_TWO_BYTE;
	endfunction

	function automatic void add_extension(int unsigned v);
		if (v >= EXT_TWO_BYTE) begin
			encoded.push_back(8'((v - EXT_TWO_BYTE) >> 8));
			encoded.push_back(8'(v - EXT_TWO_BYTE));
		end else if (v >= EXT_ONE_BYTE) begin
			encoded.push_back(8'(v - EXT_ONE_BYTE));
		end
	endfunction

	// Emits the delta/length tag; an option number below the previous one emits nothing.
	function automatic bit add_tag(int unsigned id, int unsigned len);
		int unsigned delta;
		if (id < prev_option) begin
			return 1'b0;
		end
		delta = id - prev_option;
		prev_option = 16'(id);
		encoded.push_back({tag_nibble(delta), tag_nibble(len)});
		add_extension(delta);
		add_extension(len);
		return 1'b1;
	endfunction

	// An empty Max-Age goes out ahead of option 0, the first option past 14 or the payload
	// marker. Option 14 itself cancels the insertion, options 1 to 13 leave it armed.
	function automatic void max_age_before(int unsigned id);
		if (!max_age_armed || (id != 0 && id < MAX_AGE_OPTION)) begin
			return;
		end
		if (id != MAX_AGE_OPTION) begin
			void'(add_tag(MAX_AGE_OPTION, 0));
		end
		max_age_armed = 1'b0;
	endfunction

	// Advances the message state by one transaction, leaves its bytes in encoded and
	// returns the ok flag.
	function automatic bit encode_item(coap_item_t s);
		logic [3:0]  tkl;
		int unsigned n;
		bit          okv;
		okv = 1'b1;
		encoded.delete();
		case (s.action)
			ACT_HEADER: begin
				prev_option = '0;
				max_age_armed = cfg_auto_max_age && (s.code != 8'h00);
				tkl = (s.token_len > TOKEN_MAX) ? TOKEN_MAX : s.token_len;
				if (tkl == 4'd0) begin
					tkl = 4'(count_bytes(s.token));
				end
				encoded.push_back(VER_BITS | {2'b00, s.msg_type, tkl});
				encoded.push_back(s.code);
				encoded.push_back(s.msg_id[15:8]);
				encoded.push_back(s.msg_id[7:0]);
				for (int i = int'(tkl) - 1; i >= 0; i--) begin
					encoded.push_back(s.token[8*i +: 8]);
				end
			end
			ACT_OPAQUE: begin
				max_age_before(s.option_id);
				okv = add_tag(s.option_id, s.option_len);
			end
			ACT_UINT: begin
				max_age_before(s.option_id);
				n = count_bytes(s.uint_value);
				okv = add_tag(s.option_id, n);
				if (okv) begin
					for (int i = int'(n) - 1; i >= 0; i--) begin
						encoded.push_back(s.uint_value[8*i +: 8]);
					end
				end
			end
			ACT_MARKER: begin
				max_age_before(0);
				encoded.push_back(END_OF_OPTIONS);
			end
			ACT_DATA: begin
				encoded.push_back(s.data_byte);
			end
			default: begin
			end
		endcase
		return okv;
	endfunction

	// ------------------------------------------------------------------
	// Item builders.
	// ------------------------------------------------------------------

	function automatic coap_item_t mk_header(logic [1:0] mt, logic [7:0] c, logic [15:0] mid,
			logic [63:0] tok, logic [3:0] tl);
		coap_item_t s;
		s = '0;
		s.action = ACT_HEADER;
		s.msg_type = mt;
		s.code = c;
		s.msg_id = mid;
		s.token = tok;
		s.token_len = tl;
		return s;
	endfunction

	function automatic coap_item_t mk_option(logic [2:0] a, logic [15:0] id, logic [15:0] len,
			logic [63:0] v);
		coap_item_t s;
		s = '0;
		s.action = a;
		s.option_id = id;
		s.option_len = len;
		s.uint_value = v;
		return s;
	endfunction

	function automatic coap_item_t mk_simple(logic [2:0] a, logic [7:0] d);
		coap_item_t s;
		s = '0;
		s.action = a;
		s.data_byte = d;
		return s;
	endfunction

	function automatic item_row_t predicted(coap_item_t s);
		item_row_t r;
		r = '{s, PREDICT, '0, 1'b1, 1'b1};
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sender side.
	// ------------------------------------------------------------------

	// Offers one transaction, possibly after an idle burst, and records the bytes it must
	// produce once the block has taken it. Valid stays high afterwards so that a following
	// item goes out back to back.
	task automatic offer_item(input item_row_t r);
		bit okv;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= r.item.action;
		msg_type   <= r.item.msg_type;
		code       <= r.item.code;
		msg_id     <= r.item.msg_id;
		token      <= r.item.token;
		token_len  <= r.item.token_len;
		option_id  <= r.item.option_id;
		option_len <= r.item.option_len;
		uint_value <= r.item.uint_value;
		data_byte  <= r.item.data_byte;
		do begin
			@(posedge clk);
		end while (!in_ready);
		items_sent++;
		okv = encode_item(r.item);
		if (r.exp_n != PREDICT) begin
			// Typed rows still run through the encoder so that its state stays in step.
			for (int k = 0; k < r.exp_n; k++) begin
				wire_bytes_q.push_back('{r.exp_bytes[63 - 8*k -: 8], r.exp_bv,
					k == r.exp_n - 1, r.exp_ok});
			end
		end else if (r.item.action <= ACT_DATA) begin
			if (encoded.size() == 0) begin
				// A rejected option with nothing inserted still answers with one empty result.
				wire_bytes_q.push_back('{8'h00, 1'b0, 1'b1, okv});
			end else begin
				foreach (encoded[k]) begin
					wire_bytes_q.push_back('{encoded[k], 1'b1, k == encoded.size() - 1, okv});
				end
			end
		end
	endtask

	// Holds the sender back until every expected byte is out, then lets the front end settle.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (wire_bytes_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The register only takes effect at the next header, so the encoder changes it alike.
	task automatic write_auto_max_age(input logic v);
		wait_for_drain();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_auto_max_age = v;
	endtask

	task automatic send_data_byte();
		offer_item(predicted(mk_simple(ACT_DATA, 8'($urandom))));
	endtask

	// A well-formed message: header, options in ascending order with their values,
	// and usually a payload.
	task automatic send_message();
		coap_item_t  s;
		int unsigned cur;
		int unsigned delta;
		int unsigned len;
		s = mk_header(2'($urandom), ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom),
			16'($urandom), {$urandom, $urandom} >> (8 * $urandom_range(0, 8)),
			4'($urandom_range(0, 15)));
		offer_item(predicted(s));
		cur = 0;
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9: delta = $urandom_range(0, 15);
				10, 11, 12, 13, 14, 15:       delta = $urandom_range(EXT_ONE_BYTE, EXT_TWO_BYTE);
				16, 17, 18:                   delta = $urandom_range(EXT_TWO_BYTE, 3000);
				default:                      delta = $urandom_range(0, 65535);
			endcase
			cur = (cur + delta > 65535) ? 65535 : cur + delta;
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: len = $urandom_range(0, 4);
					7, 8:                len = $urandom_range(EXT_ONE_BYTE - 1, 300);
					default:             len = $urandom_range(0, 65535);
				endcase
				offer_item(predicted(mk_option(ACT_OPAQUE, 16'(cur), 16'(len), '0)));
				// Long values only get a few bytes; the block does not count them.
				repeat ((len <= 4) ? len : $urandom_range(0, 3)) send_data_byte();
			end else begin
				offer_item(predicted(mk_option(ACT_UINT, 16'(cur), '0,
					{$urandom, $urandom} >> (8 * $urandom_range(0, 8)))));
			end
		end
		if ($urandom_range(0, 9) < 7) begin
			offer_item(predicted(mk_simple(ACT_MARKER, '0)));
			repeat ($urandom_range(1, 4)) send_data_byte();
		end
	endtask

	// Anything at all: unused actions, out-of-order options, stray headers.
	task automatic send_noise();
		coap_item_t s;
		s.action     = 3'($urandom_range(0, 7));
		s.msg_type   = 2'($urandom);
		s.code       = 8'($urandom);
		s.msg_id     = 16'($urandom);
		s.token      = {$urandom, $urandom};
		s.token_len  = 4'($urandom);
		s.option_id  = 16'($urandom);
		s.option_len = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 20)) : 16'($urandom);
		s.uint_value = {$urandom, $urandom} >> (8 * $urandom_range(0, 8));
		s.data_byte  = 8'($urandom);
		offer_item(predicted(s));
	endtask

	// ------------------------------------------------------------------
	// Receiver side: short random stalls, one long hold-off on request, none when calm.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (long_stall_req != long_stall_seen) begin
			long_stall_seen <= long_stall_req;
			stall_left <= LONG_STALL - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 12);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Every byte taken from the block is compared with the oldest one still expected.
	always @(posedge clk) begin : check_stream
		wire_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (wire_bytes_q.size() == 0) begin
				$error("result transaction with nothing expected: out_byte %02h", out_byte);
				mismatch_count++;
			end else begin
				want = wire_bytes_q.pop_front();
				if (out_byte !== want.obyte) begin
					$error("out_byte: expected %02h, got %02h", want.obyte, out_byte);
					mismatch_count++;
				end
				if (byte_valid !== want.bvalid) begin
					$error("byte_valid: expected %0b, got %0b", want.bvalid, byte_valid);
					mismatch_count++;
				end
				if (last !== want.blast) begin
					$error("last: expected %0b, got %0b", want.blast, last);
					mismatch_count++;
				end
				if (ok !== want.bok) begin
					$error("ok: expected %0b, got %0b", want.bok, ok);
					mismatch_count++;
				end
			end
		end
	end

	// The run is stuck when neither side completes a transaction for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$error("no transaction for %0d cycles", QUIET_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		int phase_start;
		bit stall_done;
		stall_done = 1'b0;

		// Directed table. Rows with bytes typed in are obvious from the encoding rules; the
		// rest go through the encoder. Auto Max-Age is on throughout.
		directed_rows = '{
			// Fresh header right after reset, automatic zero-length token.
			'{mk_header(2'd0, 8'h01, 16'h0000, 64'h0, 4'd0), 4, 64'h4001_0000_0000_0000,
				1'b1, 1'b1},
			// All-ones header; a token length above eight is clipped to eight.
			'{mk_header(2'd3, 8'hFF, 16'hFFFF, '1, 4'd15), PREDICT, '0, 1'b1, 1'b1},
			// Option 1 keeps Max-Age armed; a zero uint value has no value bytes.
			'{mk_option(ACT_UINT, 16'd1, '0, 64'h0), 1, 64'h1000_0000_0000_0000, 1'b1, 1'b1},
			'{mk_option(ACT_OPAQUE, 16'd5, 16'd12, '0), 1, 64'h4C00_0000_0000_0000, 1'b1, 1'b1},
			'{mk_option(ACT_OPAQUE, 16'd10, 16'd13, '0), 2, 64'h5D00_0000_0000_0000, 1'b1, 1'b1},
			// Descending option with nothing inserted: one empty, rejected result.
			'{mk_option(ACT_OPAQUE, 16'd3, 16'd0, '0), 1, 64'h0, 1'b0, 1'b0},
			// Option 14 itself cancels the insertion; length at the top of one-byte extension.
			'{mk_option(ACT_OPAQUE, 16'd14, 16'd268, '0), 2, 64'h4DFF_0000_0000_0000,
				1'b1, 1'b1},
			// Delta at the start of one-byte extension, length at the start of two-byte.
			'{mk_option(ACT_OPAQUE, 16'd27, 16'd269, '0), 4, 64'hDE00_0000_0000_0000,
				1'b1, 1'b1},
			'{mk_simple(ACT_DATA, 8'h00), 1, 64'h0000_0000_0000_0000, 1'b1, 1'b1},
			'{mk_simple(ACT_DATA, 8'hFF), 1, 64'hFF00_0000_0000_0000, 1'b1, 1'b1},
			'{mk_option(ACT_UINT, 16'd282, '0, 64'h0102), PREDICT, '0, 1'b1, 1'b1},
			// Largest option number and length.
			'{mk_option(ACT_OPAQUE, 16'hFFFF, 16'hFFFF, '0), PREDICT, '0, 1'b1, 1'b1},
			'{mk_simple(ACT_MARKER, '0), 1, 64'hFF00_0000_0000_0000, 1'b1, 1'b1},
			// Empty code disables Max-Age; token length worked out from the value.
			'{mk_header(2'd1, 8'h00, 16'h1234, 64'h0102, 4'd0), 6, 64'h5200_1234_0102_0000,
				1'b1, 1'b1},
			'{mk_simple(ACT_MARKER, '0), 1, 64'hFF00_0000_0000_0000, 1'b1, 1'b1},
			// Explicit token length shorter than the value: only the low bytes go out.
			'{mk_header(2'd2, 8'h45, 16'hABCD, 64'h1122_3344_5566_7788, 4'd3), 7,
				64'h6345_ABCD_6677_8800, 1'b1, 1'b1},
			// Option 0 inserts Max-Age, then falls below it: inserted bytes, all rejected.
			'{mk_option(ACT_UINT, 16'd0, '0, '1), 2, 64'hD001_0000_0000_0000, 1'b1, 1'b0},
			'{mk_option(ACT_UINT, 16'd20, '0, 64'h80), 2, 64'h6180_0000_0000_0000, 1'b1, 1'b1},
			'{mk_simple(ACT_UNUSED_FIRST, '0), PREDICT, '0, 1'b1, 1'b1},
			'{mk_header(2'd0, 8'h01, 16'h0000, 64'hFF, 4'd0), PREDICT, '0, 1'b1, 1'b1},
			// Max-Age insertion ahead of a full eight-byte uint.
			'{mk_option(ACT_UINT, 16'd100, '0, '1), PREDICT, '0, 1'b1, 1'b1},
			'{mk_simple(ACT_UNUSED_LAST, '0), PREDICT, '0, 1'b1, 1'b1},
			'{mk_simple(ACT_MARKER, '0), PREDICT, '0, 1'b1, 1'b1},
			'{mk_header(2'd0, 8'h01, 16'h0000, 64'h0, 4'd0), 4, 64'h4001_0000_0000_0000,
				1'b1, 1'b1},
			// Payload marker with Max-Age still armed.
			'{mk_simple(ACT_MARKER, '0), PREDICT, '0, 1'b1, 1'b1}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		write_auto_max_age(1'b1);
		foreach (directed_rows[i]) begin
			offer_item(directed_rows[i]);
		end

		// Random phases alternate the register; the last one runs without any idling.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_auto_max_age(ph[0]);
			calm <= (ph == NUM_PHASES - 1);
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				// One long hold-off on the output while the sender keeps pushing, so the
				// job queue fills and the input stalls.
				if (ph == 1 && !stall_done && items_sent - phase_start >= 20) begin
					long_stall_req <= ~long_stall_req;
					stall_done = 1'b1;
				end
				if ($urandom_range(0, 6) == 0) begin
					send_noise();
				end else begin
					send_message();
				end
			end
		end

		wait_for_drain();
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ coap_message_serializer_core.f @@
sv/coap_ser_pkg.sv
sv/coap_ser_front.sv
sv/coap_ser_fifo.sv
sv/coap_ser_back.sv
sv/coap_message_serializer_core.sv
bench/coap_message_serializer_core_test.sv
